FILE: rtl/source_lexer_top_assert.svh
// assertion macros shared by the lexer rtl
`ifndef SOURCE_LEXER_TOP_ASSERT_SVH
`define SOURCE_LEXER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SL_CHECK(lbl, cond) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (cond)) else $error("lexer check failed");
`define SL_CHECK_NEXT(lbl, pre, post) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (pre) |=> (post)) else $error("lexer check failed");
`else
`define SL_CHECK(lbl, cond)
`define SL_CHECK_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/srclex_pkg.sv
// types, token codes and character classes for the source lexer
package srclex_pkg;

  localparam int POS_BITS_DEF = 24;
  localparam int MAX_WORD_DEF = 255;
  localparam int TOKQ_DEPTH   = 8;
  localparam int TOKQ_LANES   = 4;

  typedef enum logic [1:0] {
    M_NORMAL = 2'd0,
    M_LINE   = 2'd1,
    M_BLOCK  = 2'd2,
    M_STRING = 2'd3
  } lex_mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCHAR = 2'd1,
    ST_DIGITID = 2'd2,
    ST_TOOLONG = 2'd3
  } lex_status_t;

  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_MINUS  = 6'd12;
  localparam logic [5:0] K_ASTER  = 6'd13;
  localparam logic [5:0] K_SLASH  = 6'd14;
  localparam logic [5:0] K_BAR    = 6'd15;
  localparam logic [5:0] K_AMP    = 6'd17;
  localparam logic [5:0] K_BANG   = 6'd19;
  localparam logic [5:0] K_ASSIGN = 6'd20;
  localparam logic [5:0] K_LT     = 6'd21;
  localparam logic [5:0] K_GT     = 6'd22;
  localparam logic [5:0] K_OROR   = 6'd23;
  localparam logic [5:0] K_ANDAND = 6'd24;
  localparam logic [5:0] K_ARROW  = 6'd25;
  localparam logic [5:0] K_SHL    = 6'd26;
  localparam logic [5:0] K_SHR    = 6'd27;
  localparam logic [5:0] K_NE     = 6'd28;
  localparam logic [5:0] K_EQ     = 6'd29;
  localparam logic [5:0] K_LE     = 6'd30;
  localparam logic [5:0] K_GE     = 6'd31;
  localparam logic [5:0] K_FN     = 6'd32;
  localparam logic [5:0] K_LET    = 6'd33;
  localparam logic [5:0] K_EXTERN = 6'd34;
  localparam logic [5:0] K_AS     = 6'd35;
  localparam logic [5:0] K_IF     = 6'd36;
  localparam logic [5:0] K_WHILE  = 6'd37;
  localparam logic [5:0] K_RETURN = 6'd38;
  localparam logic [5:0] K_BREAK  = 6'd39;
  localparam logic [5:0] K_ELSE   = 6'd40;
  localparam logic [5:0] K_IDENT  = 6'd41;
  localparam logic [5:0] K_CONST  = 6'd42;
  localparam logic [5:0] K_STRING = 6'd43;

  localparam logic [7:0] CH_IGNORE = 8'hFF;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSL    = 8'h5C;

  // kind of a one-byte punctuation or operator, zero when none
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    case (c)
      "(":     single_kind = 6'd1;
      ")":     single_kind = 6'd2;
      "[":     single_kind = 6'd3;
      "]":     single_kind = 6'd4;
      "{":     single_kind = 6'd5;
      "}":     single_kind = 6'd6;
      ",":     single_kind = 6'd7;
      ";":     single_kind = 6'd8;
      ":":     single_kind = 6'd9;
      ".":     single_kind = 6'd10;
      "+":     single_kind = 6'd11;
      "-":     single_kind = K_MINUS;
      "^":     single_kind = 6'd16;
      "~":     single_kind = 6'd18;
      "!":     single_kind = K_BANG;
      default: single_kind = K_EOF;
    endcase
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    is_delim = (c >= 8'd9 && c <= 8'd13) || c == " " || single_kind(c) != K_EOF ||
               c == "=" || c == "<" || c == ">" || c == "&" || c == "|" ||
               c == "/" || c == "*" || c == "\"";
  endfunction

  // keyword lookup on the first six bytes, byte k at bits 8k
  function automatic logic [5:0] word_kind(input logic [7:0] wc, input logic [47:0] head,
                                           input logic num);
    logic [5:0] k;
    k = num ? K_CONST : K_IDENT;
    if (wc == 8'd2 && head == 48'h6E66) k = K_FN;
    if (wc == 8'd3 && head == 48'h74656C) k = K_LET;
    if (wc == 8'd6 && head == 48'h6E7265747865) k = K_EXTERN;
    if (wc == 8'd2 && head == 48'h7361) k = K_AS;
    if (wc == 8'd2 && head == 48'h6669) k = K_IF;
    if (wc == 8'd5 && head == 48'h656C696877) k = K_WHILE;
    if (wc == 8'd6 && head == 48'h6E7275746572) k = K_RETURN;
    if (wc == 8'd5 && head == 48'h6B61657262) k = K_BREAK;
    if (wc == 8'd4 && head == 48'h65736C65) k = K_ELSE;
    word_kind = k;
  endfunction

endpackage

FILE: rtl/source_lexer_top.sv
// source lexer top level: byte in, tokens out through a short queue
// usage
//   in channel: one source byte per beat (in_char_byte), in_end_of_text on
//   the last byte of the text. byte 0xff is skipped but still counted.
//   out channel: one token per beat: kind, start offset, length, status and
//   final_token, which marks the eof or error token that ends the run.
// flow and throughput
//   an accepted byte is lexed in the cycle it is taken; its tokens (zero to
//   four) are written into an eight-entry queue and reach out_ from its
//   registers in order. one byte per cycle is taken while the queue has four
//   free entries, so the sustained rate is set by the one-token-per-cycle
//   queue read port, which stalls while out_ready is low.
// reset
//   rst_n low clears the lexer state and empties the queue; the first byte
//   after reset is at offset zero.
// stalls
//   while out_ready is low tokens wait in the queue; in_ready drops when
//   fewer than four entries are free. after the final token every byte is
//   taken and dropped until the next reset.
`include "source_lexer_top_assert.svh"
module source_lexer_top #(
  parameter int POS_BITS = srclex_pkg::POS_BITS_DEF,
  parameter int MAX_WORD = srclex_pkg::MAX_WORD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char_byte,
  input  logic                in_end_of_text,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [5:0]          out_token_kind,
  output logic [POS_BITS-1:0] out_start_pos,
  output logic [8:0]          out_token_len,
  output logic [1:0]          out_status,
  output logic                out_final_token
);
  localparam int LANES = srclex_pkg::TOKQ_LANES;
  localparam int TW    = 6 + POS_BITS + 9 + 2 + 1;
  localparam int NW    = $clog2(LANES + 1);

  // lexer state
  srclex_pkg::lex_mode_t mode_r, mode_nxt;
  logic [POS_BITS-1:0]   byte_pos_r, byte_pos_nxt;
  logic [7:0]            wc_r, wc_nxt;
  logic [47:0]           head_r, head_nxt;
  logic                  num_r, num_nxt;
  logic                  esc_r, esc_nxt;
  logic [7:0]            prior_r, prior_nxt;
  logic [5:0]            hk_r, hk_nxt;
  logic [POS_BITS-1:0]   hs_r, hs_nxt;
  logic [8:0]            hl_r, hl_nxt;
  logic                  hv_r, hv_nxt;
  logic                  stop_r, stop_nxt;

  // tokens produced by this beat
  logic [LANES-1:0][TW-1:0] em;
  logic [NW-1:0]            ne;
  logic [1:0]               err;
  logic                     acc;
  logic [7:0]               c;
  logic [5:0]               sk;
  logic [TW-1:0]            q_data;

  assign acc = in_valid && in_ready;
  assign c   = in_char_byte;
  assign sk  = srclex_pkg::single_kind(c);

  always_comb begin
    mode_nxt     = mode_r;
    byte_pos_nxt = byte_pos_r;
    wc_nxt       = wc_r;
    head_nxt     = head_r;
    num_nxt      = num_r;
    esc_nxt      = esc_r;
    prior_nxt    = prior_r;
    hk_nxt       = hk_r;
    hs_nxt       = hs_r;
    hl_nxt       = hl_r;
    hv_nxt       = hv_r;
    stop_nxt     = stop_r;
    em           = '0;
    ne           = '0;
    err          = srclex_pkg::ST_OK;
    if (acc && !stop_r) begin
      byte_pos_nxt = byte_pos_r + POS_BITS'(1);
      if (c != srclex_pkg::CH_IGNORE) begin
        case (mode_r)
          srclex_pkg::M_LINE: begin
            if (c == srclex_pkg::CH_LF) mode_nxt = srclex_pkg::M_NORMAL;
          end
          srclex_pkg::M_BLOCK: begin
            if (prior_r == "*" && c == "/") mode_nxt = srclex_pkg::M_NORMAL;
          end
          srclex_pkg::M_STRING: begin
            if (c == "\"" && !esc_r) begin
              if (hv_nxt) begin
                em[ne[1:0]] = {hk_nxt, hs_nxt, hl_nxt, 3'b000};
                ne = ne + NW'(1);
              end
              hk_nxt   = srclex_pkg::K_STRING;
              hs_nxt   = byte_pos_r - POS_BITS'(wc_r) - POS_BITS'(1);
              hl_nxt   = 9'(wc_r) + 9'd2;
              hv_nxt   = 1'b1;
              mode_nxt = srclex_pkg::M_NORMAL;
              wc_nxt   = '0;
              head_nxt = '0;
            end else begin
              esc_nxt = (c == srclex_pkg::CH_BSL) ? !esc_r : 1'b0;
              if (wc_r >= 8'(MAX_WORD)) err = srclex_pkg::ST_TOOLONG;
              else wc_nxt = wc_r + 8'd1;
            end
          end
          default: begin
            if (srclex_pkg::is_delim(c)) begin
              // close an open word first, it becomes the held token
              if (wc_r != '0) begin
                if (hv_nxt) begin
                  em[ne[1:0]] = {hk_nxt, hs_nxt, hl_nxt, 3'b000};
                  ne = ne + NW'(1);
                end
                hk_nxt = srclex_pkg::word_kind(wc_r, head_r, num_r);
                hs_nxt = byte_pos_r - POS_BITS'(wc_r);
                hl_nxt = 9'(wc_r);
                hv_nxt = 1'b1;
              end
              begin : op_blk
                logic [5:0] mk;
                logic [5:0] pk;
                mk = srclex_pkg::K_EOF;
                pk = srclex_pkg::K_EOF;
                if (c == "=") begin
                  if (hv_nxt && hk_nxt == srclex_pkg::K_ASSIGN) mk = srclex_pkg::K_EQ;
                  else if (hv_nxt && hk_nxt == srclex_pkg::K_GT) mk = srclex_pkg::K_GE;
                  else if (hv_nxt && hk_nxt == srclex_pkg::K_LT) mk = srclex_pkg::K_LE;
                  else if (hv_nxt && hk_nxt == srclex_pkg::K_BANG) mk = srclex_pkg::K_NE;
                  else pk = srclex_pkg::K_ASSIGN;
                end else if (c == "/" || c == "*") begin
                  if (hv_nxt && hk_nxt == srclex_pkg::K_SLASH) begin
                    // comment opener: the held slash is dropped
                    hv_nxt   = 1'b0;
                    mode_nxt = (c == "/") ? srclex_pkg::M_LINE : srclex_pkg::M_BLOCK;
                  end else begin
                    pk = (c == "/") ? srclex_pkg::K_SLASH : srclex_pkg::K_ASTER;
                  end
                end else if (c == "&") begin
                  if (hv_nxt && hk_nxt == srclex_pkg::K_AMP) mk = srclex_pkg::K_ANDAND;
                  else pk = srclex_pkg::K_AMP;
                end else if (c == "|") begin
                  if (hv_nxt && hk_nxt == srclex_pkg::K_BAR) mk = srclex_pkg::K_OROR;
                  else pk = srclex_pkg::K_BAR;
                end else if (c == "<") begin
                  if (hv_nxt && hk_nxt == srclex_pkg::K_LT) mk = srclex_pkg::K_SHL;
                  else pk = srclex_pkg::K_LT;
                end else if (c == ">") begin
                  if (hv_nxt && hk_nxt == srclex_pkg::K_GT) mk = srclex_pkg::K_SHR;
                  else if (hv_nxt && hk_nxt == srclex_pkg::K_MINUS) mk = srclex_pkg::K_ARROW;
                  else pk = srclex_pkg::K_GT;
                end else if (c == "\"") begin
                  mode_nxt = srclex_pkg::M_STRING;
                end else begin
                  pk = sk;
                end
                if (mk != srclex_pkg::K_EOF) begin
                  hk_nxt = mk;
                  if (hl_nxt != 9'h1FF) hl_nxt = hl_nxt + 9'd1;
                end
                if (pk != srclex_pkg::K_EOF) begin
                  if (hv_nxt) begin
                    em[ne[1:0]] = {hk_nxt, hs_nxt, hl_nxt, 3'b000};
                    ne = ne + NW'(1);
                  end
                  hk_nxt = pk;
                  hs_nxt = byte_pos_r;
                  hl_nxt = 9'd1;
                  hv_nxt = 1'b1;
                end
              end
              wc_nxt   = '0;
              head_nxt = '0;
              num_nxt  = 1'b0;
            end else if (c >= "0" && c <= "9") begin
              if (wc_r == '0) num_nxt = 1'b1;
              if (wc_r >= 8'(MAX_WORD)) err = srclex_pkg::ST_TOOLONG;
              else begin
                if (wc_r < 8'd6) head_nxt = head_r | (48'(c) << {wc_r[2:0], 3'b000});
                wc_nxt = wc_r + 8'd1;
              end
            end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
              if (num_r) err = srclex_pkg::ST_DIGITID;
              else if (wc_r >= 8'(MAX_WORD)) err = srclex_pkg::ST_TOOLONG;
              else begin
                if (wc_r < 8'd6) head_nxt = head_r | (48'(c) << {wc_r[2:0], 3'b000});
                wc_nxt = wc_r + 8'd1;
              end
            end else begin
              err = srclex_pkg::ST_BADCHAR;
            end
          end
        endcase
        if (err != srclex_pkg::ST_OK) begin
          // error: flush the held token, then the error token ends the run
          if (hv_nxt) begin
            em[ne[1:0]] = {hk_nxt, hs_nxt, hl_nxt, 3'b000};
            ne = ne + NW'(1);
          end
          hv_nxt = 1'b0;
          em[ne[1:0]] = {srclex_pkg::K_EOF, byte_pos_r, 9'd0, err, 1'b1};
          ne = ne + NW'(1);
          stop_nxt = 1'b1;
        end else begin
          prior_nxt = c;
        end
      end
      if (in_end_of_text && err == srclex_pkg::ST_OK) begin
        if (hv_nxt) begin
          em[ne[1:0]] = {hk_nxt, hs_nxt, hl_nxt, 3'b000};
          ne = ne + NW'(1);
        end
        hv_nxt = 1'b0;
        em[ne[1:0]] = {srclex_pkg::K_EOF, byte_pos_nxt, 9'd0, srclex_pkg::ST_OK, 1'b1};
        ne = ne + NW'(1);
        stop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= srclex_pkg::M_NORMAL;
      byte_pos_r <= '0;
      wc_r       <= '0;
      head_r     <= '0;
      num_r      <= 1'b0;
      esc_r      <= 1'b0;
      prior_r    <= '0;
      hk_r       <= '0;
      hs_r       <= '0;
      hl_r       <= '0;
      hv_r       <= 1'b0;
      stop_r     <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      byte_pos_r <= byte_pos_nxt;
      wc_r       <= wc_nxt;
      head_r     <= head_nxt;
      num_r      <= num_nxt;
      esc_r      <= esc_nxt;
      prior_r    <= prior_nxt;
      hk_r       <= hk_nxt;
      hs_r       <= hs_nxt;
      hl_r       <= hl_nxt;
      hv_r       <= hv_nxt;
      stop_r     <= stop_nxt;
    end
  end

  srclex_tokq #(
    .WIDTH(TW)
  ) u_tokq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (ne),
    .push_data(em),
    .room     (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (q_data)
  );

  assign {out_token_kind, out_start_pos, out_token_len, out_status, out_final_token} = q_data;

  // once stopped the lexer stays stopped and emits nothing
  `SL_CHECK_NEXT(a_stop_sticky, stop_r, stop_r)
  `SL_CHECK(a_stop_silent, !stop_r || ne == '0)
  `SL_CHECK(a_final_last, ne == '0 || !em[ne[1:0] - 2'd1][0] || stop_nxt)
endmodule

FILE: rtl/srclex_tokq.sv
// token queue: up to four beats written per cycle, one read per cycle while out_ready is high
`include "source_lexer_top_assert.svh"
module srclex_tokq #(
  parameter int WIDTH = 42
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic [$clog2(srclex_pkg::TOKQ_LANES+1)-1:0]  push_n,
  input  logic [srclex_pkg::TOKQ_LANES-1:0][WIDTH-1:0] push_data,
  output logic                                         room,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [WIDTH-1:0]                             out_data
);
  localparam int DEPTH = srclex_pkg::TOKQ_DEPTH;
  localparam int LANES = srclex_pkg::TOKQ_LANES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign room      = count_r <= CW'(DEPTH - LANES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + AW'(1);
      count_r <= count_r + CW'(push_n) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (k < int'(push_n)) mem_r[wr_ptr_r + AW'(k)] <= push_data[k];
    end
  end

  `SL_CHECK(a_count_bound, count_r <= CW'(DEPTH))
  `SL_CHECK(a_push_fits, push_n == '0 || (count_r + CW'(push_n)) <= CW'(DEPTH))
  `SL_CHECK_NEXT(a_pop_only, pop && push_n == '0, count_r == $past(count_r) - CW'(1))
endmodule

FILE: tb/testbench.sv
// self-checking testbench for the source lexer: random source text, token scoreboard
`timescale 1ns / 100ps
module testbench;

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] start;
    logic [8:0]  len;
    logic [1:0]  status;
    logic        fin;
  } token_t;

  // token prediction and in-order checking
  class token_scoreboard;
    srclex_pkg::lex_mode_t mode;
    logic [23:0] pos;
    int          wcount;
    string       whead;
    bit          wnum, esc, held_ok, halted;
    logic [7:0]  prev;
    logic [5:0]  hkind;
    logic [23:0] hstart;
    logic [8:0]  hlen;
    token_t      expect_q[$];
    int          errs, checked, noted;
    string       kw_txt[9] = '{"fn", "let", "extern", "as", "if", "while", "return",
                               "break", "else"};
    logic [5:0]  kw_kind[9] = '{srclex_pkg::K_FN, srclex_pkg::K_LET, srclex_pkg::K_EXTERN,
                                srclex_pkg::K_AS, srclex_pkg::K_IF, srclex_pkg::K_WHILE,
                                srclex_pkg::K_RETURN, srclex_pkg::K_BREAK,
                                srclex_pkg::K_ELSE};

    function new();
      mode = srclex_pkg::M_NORMAL;
      pos = '0;
      wcount = 0;
      whead = "";
      prev = '0;
      hkind = srclex_pkg::K_EOF;
      hstart = '0;
      hlen = '0;
    endfunction

    function void add(logic [5:0] k, logic [23:0] s, logic [8:0] l, logic [1:0] st,
                      logic f);
      token_t t;
      t = '{kind: k, start: s, len: l, status: st, fin: f};
      expect_q.push_back(t);
    endfunction

    function void flush();
      if (held_ok) add(hkind, hstart, hlen, srclex_pkg::ST_OK, 1'b0);
      held_ok = 0;
    endfunction

    function void hold(logic [5:0] k, logic [23:0] s, logic [8:0] l);
      flush();
      hkind = k;
      hstart = s;
      hlen = l;
      held_ok = 1;
    endfunction

    function bit held(logic [5:0] k);
      return held_ok && hkind == k;
    endfunction

    function void combine(logic [5:0] k);
      hkind = k;
      if (hlen != 9'h1FF) hlen = hlen + 9'd1;
    endfunction

    function logic [5:0] punct(logic [7:0] c);
      case (c)
        "(": return 6'd1;
        ")": return 6'd2;
        "[": return 6'd3;
        "]": return 6'd4;
        "{": return 6'd5;
        "}": return 6'd6;
        ",": return 6'd7;
        ";": return 6'd8;
        ":": return 6'd9;
        ".": return 6'd10;
        "+": return 6'd11;
        "-": return srclex_pkg::K_MINUS;
        "^": return 6'd16;
        "~": return 6'd18;
        "!": return srclex_pkg::K_BANG;
        default: return srclex_pkg::K_EOF;
      endcase
    endfunction

    function bit delim(logic [7:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == " " || punct(c) != srclex_pkg::K_EOF ||
             c == "=" || c == "<" || c == ">" || c == "&" || c == "|" || c == "/" ||
             c == "*" || c == "\"";
    endfunction

    function logic [5:0] classify();
      foreach (kw_txt[k])
        if (wcount == kw_txt[k].len() && whead == kw_txt[k]) return kw_kind[k];
      return wnum ? srclex_pkg::K_CONST : srclex_pkg::K_IDENT;
    endfunction

    function srclex_pkg::lex_status_t grow(logic [7:0] c);
      if (wcount >= srclex_pkg::MAX_WORD_DEF) return srclex_pkg::ST_TOOLONG;
      if (wcount < 6) whead = {whead, string'(c)};
      wcount++;
      return srclex_pkg::ST_OK;
    endfunction

    function srclex_pkg::lex_status_t lex_normal(logic [7:0] c, logic [23:0] i);
      if (delim(c)) begin
        if (wcount > 0) hold(classify(), i - 24'(wcount), 9'(wcount));
        if (c == "=") begin
          if (held(srclex_pkg::K_ASSIGN)) combine(srclex_pkg::K_EQ);
          else if (held(srclex_pkg::K_GT)) combine(srclex_pkg::K_GE);
          else if (held(srclex_pkg::K_LT)) combine(srclex_pkg::K_LE);
          else if (held(srclex_pkg::K_BANG)) combine(srclex_pkg::K_NE);
          else hold(srclex_pkg::K_ASSIGN, i, 9'd1);
        end else if (c == "/" || c == "*") begin
          if (held(srclex_pkg::K_SLASH)) begin
            held_ok = 0;
            mode = (c == "/") ? srclex_pkg::M_LINE : srclex_pkg::M_BLOCK;
          end else hold(c == "/" ? srclex_pkg::K_SLASH : srclex_pkg::K_ASTER, i, 9'd1);
        end else if (c == "&") begin
          if (held(srclex_pkg::K_AMP)) combine(srclex_pkg::K_ANDAND);
          else hold(srclex_pkg::K_AMP, i, 9'd1);
        end else if (c == "|") begin
          if (held(srclex_pkg::K_BAR)) combine(srclex_pkg::K_OROR);
          else hold(srclex_pkg::K_BAR, i, 9'd1);
        end else if (c == "<") begin
          if (held(srclex_pkg::K_LT)) combine(srclex_pkg::K_SHL);
          else hold(srclex_pkg::K_LT, i, 9'd1);
        end else if (c == ">") begin
          if (held(srclex_pkg::K_GT)) combine(srclex_pkg::K_SHR);
          else if (held(srclex_pkg::K_MINUS)) combine(srclex_pkg::K_ARROW);
          else hold(srclex_pkg::K_GT, i, 9'd1);
        end else if (c == "\"") begin
          mode = srclex_pkg::M_STRING;
        end else if (punct(c) != srclex_pkg::K_EOF) begin
          hold(punct(c), i, 9'd1);
        end
        wcount = 0;
        whead = "";
        wnum = 0;
        return srclex_pkg::ST_OK;
      end
      if (c >= "0" && c <= "9") begin
        if (wcount == 0) wnum = 1;
        return grow(c);
      end
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
        if (wnum) return srclex_pkg::ST_DIGITID;
        return grow(c);
      end
      return srclex_pkg::ST_BADCHAR;
    endfunction

    function srclex_pkg::lex_status_t lex_byte(logic [7:0] c, logic [23:0] i);
      case (mode)
        srclex_pkg::M_LINE: begin
          if (c == srclex_pkg::CH_LF) mode = srclex_pkg::M_NORMAL;
          return srclex_pkg::ST_OK;
        end
        srclex_pkg::M_BLOCK: begin
          if (prev == "*" && c == "/") mode = srclex_pkg::M_NORMAL;
          return srclex_pkg::ST_OK;
        end
        srclex_pkg::M_STRING: begin
          if (c == "\"" && !esc) begin
            hold(srclex_pkg::K_STRING, i - 24'(wcount + 1), 9'(wcount + 2));
            mode = srclex_pkg::M_NORMAL;
            wcount = 0;
            whead = "";
            return srclex_pkg::ST_OK;
          end
          esc = (c == srclex_pkg::CH_BSL) ? !esc : 1'b0;
          if (wcount >= srclex_pkg::MAX_WORD_DEF) return srclex_pkg::ST_TOOLONG;
          wcount++;
          return srclex_pkg::ST_OK;
        end
        default: return lex_normal(c, i);
      endcase
    endfunction

    // one accepted source byte
    function void note_byte(logic [7:0] c, logic last);
      logic [23:0] i;
      srclex_pkg::lex_status_t st;
      i = pos;
      noted++;
      if (halted) return;
      pos = pos + 24'd1;
      if (c != srclex_pkg::CH_IGNORE) begin
        st = lex_byte(c, i);
        if (st != srclex_pkg::ST_OK) begin
          flush();
          add(srclex_pkg::K_EOF, i, 9'd0, st, 1'b1);
          halted = 1;
          return;
        end
        prev = c;
      end
      if (last) begin
        flush();
        add(srclex_pkg::K_EOF, pos, 9'd0, srclex_pkg::ST_OK, 1'b1);
        halted = 1;
      end
    endfunction

    function void check(token_t got);
      token_t want;
      if (expect_q.size() == 0) begin
        errs++;
        if (errs <= 10)
          $display("unexpected token kind=%0d start=%0d len=%0d st=%0d fin=%0b",
                   got.kind, got.start, got.len, got.status, got.fin);
        return;
      end
      want = expect_q.pop_front();
      checked++;
      if (got !== want) begin
        errs++;
        if (errs <= 10)
          $display({"token %0d mismatch: exp kind=%0d start=%0d len=%0d st=%0d fin=%0b,",
                    " got kind=%0d start=%0d len=%0d st=%0d fin=%0b"},
                   checked, want.kind, want.start, want.len, want.status, want.fin,
                   got.kind, got.start, got.len, got.status, got.fin);
      end
    endfunction
  endclass

  localparam int LIMIT = 400000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  in_char_byte = '0;
  logic        in_end_of_text = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [5:0]  out_token_kind;
  logic [23:0] out_start_pos;
  logic [8:0]  out_token_len;
  logic [1:0]  out_status;
  logic        out_final_token;

  token_scoreboard sb = new();
  logic [8:0]  src_q[$];   // {end_of_text, byte}
  int          sent;
  int          cycles;
  bit          calm, squeeze, squeeze_done;

  source_lexer_top dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // ---- source text builders ----
  task automatic put_str(input string s);
    foreach (s[k]) src_q.push_back({1'b0, s[k]});
  endtask

  function automatic logic [7:0] pick_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  // delimiter that closes a word: white space or an operator byte
  task automatic put_delim();
    string ops;
    ops = "=,()[]{}<>~&|!+-;:.^*";
    case ($urandom_range(0, 3))
      0: src_q.push_back({1'b0, 8'($urandom_range(9, 13))});
      1: put_str(" ");
      default: src_q.push_back({1'b0, ops[$urandom_range(0, ops.len() - 1)]});
    endcase
  endtask

  task automatic put_word(input int n, input bit digits);
    for (int k = 0; k < n; k++)
      src_q.push_back({1'b0, digits ? 8'($urandom_range("0", "9")) :
                       (k > 0 && $urandom_range(0, 2) == 0) ? 8'($urandom_range("0", "9")) :
                       pick_letter()});
  endtask

  // string body with escapes; any byte but a bare quote
  task automatic put_string(input int n);
    logic [7:0] c;
    put_str("\"");
    for (int k = 0; k < n; k++) begin
      c = 8'($urandom_range(0, 255));
      if (c == "\"" || c == srclex_pkg::CH_BSL) begin
        src_q.push_back({1'b0, srclex_pkg::CH_BSL});
        k++;
      end
      src_q.push_back({1'b0, c});
    end
    put_str("\"");
  endtask

  task automatic put_comment(input bit block);
    int n;
    logic [7:0] c;
    n = $urandom_range(0, 10);
    put_str(block ? "/*" : "//");
    for (int k = 0; k < n; k++) begin
      c = 8'($urandom_range(0, 255));
      if (!block && c == srclex_pkg::CH_LF) c = "x";
      if (block && c == "/") c = "y";
      src_q.push_back({1'b0, c});
    end
    if (block) put_str("*/");
    else src_q.push_back({1'b0, srclex_pkg::CH_LF});
  endtask

  task automatic put_random_piece();
    string kw[9] = '{"fn", "let", "extern", "as", "if", "while", "return", "break", "else"};
    string ops[18] = '{"==", ">=", "<=", "!=", "&&", "||", "<<", ">>", "->", "=", "<",
                       ">", "!", "-", "/", "*", "& &", "- >"};
    case ($urandom_range(0, 11))
      0, 1: begin put_str(kw[$urandom_range(0, 8)]); put_delim(); end
      2, 3: begin put_word($urandom_range(1, 9), 0); put_delim(); end
      4:    begin put_word($urandom_range(1, 7), 1); put_delim(); end
      5, 6: begin put_str(ops[$urandom_range(0, 17)]); if ($urandom_range(0, 1)) put_str(" "); end
      7:    put_string($urandom_range(0, 8));
      8:    put_comment($urandom_range(0, 1));
      9:    src_q.push_back({1'b0, srclex_pkg::CH_IGNORE});
      default: put_delim();
    endcase
  endtask

  // how the text ends: clean end of text or one of the error stops
  task automatic put_ending(input int sel);
    logic [7:0] bad;
    put_str(" ");
    case (sel)
      0: begin
        put_word($urandom_range(1, 4), 0);
        src_q[$][8] = 1'b1;
      end
      1: begin
        bad = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hFE)) : "#";
        src_q.push_back({1'b0, bad});
      end
      2: put_str("7q");
      default: put_word(256, 0);   // one byte past the longest word
    endcase
    // bytes after the stop are taken and dropped
    put_str("ab");
    src_q.push_back({1'b1, 8'h7F});
  endtask

  task automatic send_byte(input logic [8:0] b);
    in_valid <= 1'b1;
    in_char_byte <= b[7:0];
    in_end_of_text <= b[8];
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // ---- monitors ----
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_char_byte, in_end_of_text);
      if (out_valid && out_ready)
        sb.check('{kind: out_token_kind, start: out_start_pos, len: out_token_len,
                   status: out_status, fin: out_final_token});
    end
  end

  initial begin
    wait (cycles > LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, one long hold-off so the queue fills and in_ready drops
  initial begin
    @(posedge rst_n);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (squeeze && !squeeze_done) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        squeeze_done = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    int n;
    int end_sel;
    // directed: leading '=', every keyword, punctuation and merged operator
    put_str("= fn let extern as if while return break else ( ) [ ] { } , ; : . + - * / | ^ ");
    put_str("& ~ ! < > || && -> << >> != == <= >= x= =y A0 123 ");
    put_str("a/*c**/b //z\n/ /\"a\\\"b\\\\\"\"\" ");
    // one word interrupted by skipped bytes
    src_q.push_back({1'b0, srclex_pkg::CH_IGNORE});
    put_str("q");
    src_q.push_back({1'b0, srclex_pkg::CH_IGNORE});
    put_str("r ");
    // the overlong-word ending brings its own 256 bytes
    end_sel = $urandom_range(0, 3);
    while (src_q.size() < ((end_sel == 3) ? 170 : 365)) put_random_piece();
    put_ending(end_sel);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (src_q[k]) begin
      if (k >= src_q.size() - 60) calm = 1;
      if (k == 200) squeeze = 1;
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      send_byte(src_q[k]);
    end
    in_valid <= 1'b0;
    calm = 1;
    n = 0;
    while (sb.expect_q.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (30) @(posedge clk);
    sb.errs += sb.expect_q.size();
    $display("fed %0d source bytes, checked %0d tokens, %0d errors",
             sb.noted, sb.checked, sb.errs);
    if (sb.errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/srclex_pkg.sv
rtl/srclex_tokq.sv
rtl/source_lexer_top.sv
tb/testbench.sv
